FILE: hw/rtl/soc_pkg.sv
// Shared types and constants for the substring occurrence counter.
package soc_pkg;

    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 10;
    localparam int SYMBOLS = 256;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 10'd1023;

    localparam logic KIND_PATTERN = 1'b0;
    localparam logic KIND_TEXT    = 1'b1;

    // One input transfer.
    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] data_byte;
        logic              last;
    } soc_in_t;

    // One result transfer.
    typedef struct packed {
        logic [COUNT_W-1:0] match_count;
        logic               found;
        logic               pattern_overflow;
    } soc_out_t;

    // Control of the per-symbol position mask table.
    typedef struct packed {
        logic              rd_en;
        logic [BYTE_W-1:0] rd_addr;
        logic              wr_en;
        logic [BYTE_W-1:0] wr_addr;
        logic              clr;
        logic [BYTE_W-1:0] vld_addr;
    } soc_mask_ctl_t;

    // Sequencer that rebuilds one prefix-match bit after a pattern byte is appended.
    typedef enum logic [1:0] {
        RC_IDLE,
        RC_ISSUE,
        RC_DRAIN
    } soc_rc_state_t;

endpackage

FILE: hw/rtl/substring_occurrence_counter_core.sv
// Top level of the overlapping substring occurrence counter.
//
// Input channel s_*: pattern bytes (kind 0) load the pattern, last closing it;
// text bytes (kind 1) are scanned, last closing the text. Result channel m_*:
// one transfer per text with last set, carrying the overlapping match count
// (saturating at 1023), a found flag and the pattern overflow flag.
// Matching is shift-and: a table indexed by byte value holds a position mask
// per symbol, read as each byte is accepted, and a prefix-match vector advances
// once per text byte, so text streams at one byte per cycle unless a rebuild
// or a stalled output holds it. The result is registered as the last text byte
// leaves stage one. Pattern bytes flow likewise, except when the store has room
// and more text bytes of the current text have been seen than the byte's
// pattern position: then the new prefix bit is rebuilt from the text window
// memory, one byte per cycle, while input is held.
// The result sits in an output register; while it is stalled, text keeps
// flowing until another last text byte needs the register, which then holds.
// Reset (aresetn low, synchronous) empties the pattern, text state and result.
module substring_occurrence_counter_core #(
    parameter int PATTERN_MAX = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  soc_pkg::soc_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output soc_pkg::soc_out_t m_data
);

    localparam int IW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int LW = $clog2(PATTERN_MAX + 1);
    localparam logic [LW-1:0]          PMAX_L  = LW'(PATTERN_MAX);
    localparam logic [IW-1:0]          PLAST_I = IW'(PATTERN_MAX - 1);
    localparam logic [PATTERN_MAX-1:0] ONE_P   = PATTERN_MAX'(1);

    // Stage-one item and pattern/text state.
    logic                           s1_valid_reg, s1_valid_next;
    soc_pkg::soc_in_t               s1_item_reg;
    logic [LW-1:0]                  len_reg, len_next;
    logic                           load_open_reg, load_open_next;
    logic                           ovf_reg, ovf_next;
    logic [LW-1:0]                  seen_reg, seen_next;
    logic [soc_pkg::COUNT_W-1:0]    count_reg, count_next;
    logic [PATTERN_MAX-1:0]         dv_reg, dv_next;
    logic [IW-1:0]                  wp_reg, wp_next;
    logic                           fwd_valid_reg;
    logic [soc_pkg::BYTE_W-1:0]     fwd_addr_reg;
    logic [PATTERN_MAX-1:0]         fwd_data_reg;

    // Rebuild sequencer.
    soc_pkg::soc_rc_state_t         rc_state_reg, rc_state_next;
    logic [IW-1:0]                  rp_reg, rp_next;
    logic [IW-1:0]                  bp_reg, bp_next;
    logic [IW-1:0]                  rc_pos_reg, rc_pos_next;
    logic                           acc_reg, acc_next;
    logic                           p1_valid_reg, p2_valid_reg;
    logic [IW-1:0]                  p1_bp_reg, p2_bp_reg;
    logic [soc_pkg::BYTE_W-1:0]     p2_byte_reg;
    logic                           rc_issue, rc_busy, rc_done;

    // Output register.
    logic                           m_valid_reg, m_valid_next;
    soc_pkg::soc_out_t              m_data_reg;

    // Datapath signals.
    logic                           accept;
    logic                           s1_is_text, s1_stall, s1_fire;
    logic                           start_now, room, rc_need, hit, out_load;
    logic [LW-1:0]                  len_eff, len_m1;
    logic [PATTERN_MAX-1:0]         mask_raw, mask_eff, pos_bit, dv_text;
    logic [soc_pkg::COUNT_W-1:0]    count_inc;
    soc_pkg::soc_mask_ctl_t         mask_ctl;
    logic [PATTERN_MAX-1:0]         mask_wr_data, mask_rd_data;
    logic                           mask_vld;
    logic [soc_pkg::BYTE_W-1:0]     win_rd_data;

    soc_mask_table #(
        .PATTERN_MAX(PATTERN_MAX)
    ) u_mask (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (mask_ctl),
        .wr_data (mask_wr_data),
        .rd_data (mask_rd_data),
        .vld     (mask_vld)
    );

    soc_text_window #(
        .PATTERN_MAX(PATTERN_MAX),
        .IW         (IW)
    ) u_window (
        .aclk    (aclk),
        .wr_en   (s1_fire && s1_is_text),
        .wr_addr (wp_reg),
        .wr_data (s1_item_reg.data_byte),
        .rd_en   (rc_issue),
        .rd_addr (rp_reg),
        .rd_data (win_rd_data)
    );

    // Stage-one decode and handshake.
    always_comb begin
        s1_is_text = (s1_item_reg.kind == soc_pkg::KIND_TEXT);
        s1_stall   = s1_valid_reg && s1_is_text && s1_item_reg.last
                     && m_valid_reg && !m_ready;
        s1_fire    = s1_valid_reg && !s1_stall;
        start_now  = !s1_is_text && !load_open_reg;
        len_eff    = start_now ? '0 : len_reg;
        room       = (len_eff < PMAX_L);
        rc_need    = s1_valid_reg && !s1_is_text && room && (seen_reg > len_eff);
        s_ready    = !s1_stall && !rc_need && !rc_busy;
        accept     = s_valid && s_ready;
    end

    // Forward the previous cycle's table write, apply valid bits.
    always_comb begin
        mask_raw = (fwd_valid_reg && (fwd_addr_reg == s1_item_reg.data_byte))
                   ? fwd_data_reg : mask_rd_data;
        mask_eff = (start_now || !mask_vld) ? '0 : mask_raw;
        pos_bit  = ONE_P << len_eff[IW-1:0];
        dv_text  = ((dv_reg << 1) | ONE_P) & mask_eff;
        len_m1   = len_reg - LW'(1);
        hit      = (len_reg != '0) && dv_text[len_m1[IW-1:0]];
        count_inc = (hit && (count_reg != soc_pkg::COUNT_MAX))
                    ? count_reg + soc_pkg::COUNT_W'(1) : count_reg;
        out_load = s1_fire && s1_is_text && s1_item_reg.last;
    end

    // Table port control.
    always_comb begin
        mask_ctl.rd_en    = accept || p1_valid_reg;
        mask_ctl.rd_addr  = p1_valid_reg ? win_rd_data : s_data.data_byte;
        mask_ctl.wr_en    = s1_fire && !s1_is_text && room;
        mask_ctl.wr_addr  = s1_item_reg.data_byte;
        mask_ctl.clr      = s1_fire && start_now;
        mask_ctl.vld_addr = p2_valid_reg ? p2_byte_reg : s1_item_reg.data_byte;
        mask_wr_data      = mask_eff | pos_bit;
    end

    // Next pattern and text state.
    always_comb begin
        s1_valid_next  = accept;
        len_next       = len_reg;
        load_open_next = load_open_reg;
        ovf_next       = ovf_reg;
        seen_next      = seen_reg;
        count_next     = count_reg;
        dv_next        = dv_reg;
        wp_next        = wp_reg;
        if (s1_fire && !s1_is_text) begin
            // Append a pattern byte, or drop it past the store.
            load_open_next = !s1_item_reg.last;
            if (start_now) begin
                dv_next  = '0;
                ovf_next = 1'b0;
            end
            if (room) begin
                len_next = len_eff + LW'(1);
            end else begin
                len_next = len_eff;
                ovf_next = 1'b1;
            end
        end else if (s1_fire) begin
            // Advance the window and the prefix-match vector.
            wp_next = (wp_reg == PLAST_I) ? '0 : wp_reg + IW'(1);
            if (s1_item_reg.last) begin
                seen_next  = '0;
                count_next = '0;
                dv_next    = '0;
            end else begin
                seen_next  = (seen_reg == PMAX_L) ? seen_reg : seen_reg + LW'(1);
                count_next = count_inc;
                dv_next    = dv_text;
            end
        end
        if (rc_done) begin
            dv_next[rc_pos_reg] = acc_reg;
        end
    end

    // Rebuild sequencer: next state.
    always_comb begin
        rc_state_next = rc_state_reg;
        case (rc_state_reg)
            soc_pkg::RC_IDLE: begin
                if (s1_fire && rc_need) begin
                    rc_state_next = soc_pkg::RC_ISSUE;
                end
            end
            soc_pkg::RC_ISSUE: begin
                if (bp_reg == '0) begin
                    rc_state_next = soc_pkg::RC_DRAIN;
                end
            end
            soc_pkg::RC_DRAIN: begin
                if (!p1_valid_reg && !p2_valid_reg) begin
                    rc_state_next = soc_pkg::RC_IDLE;
                end
            end
            default: begin
                rc_state_next = soc_pkg::RC_IDLE;
            end
        endcase
    end

    // Rebuild sequencer: outputs.
    always_comb begin
        rc_issue = 1'b0;
        rc_busy  = 1'b1;
        rc_done  = 1'b0;
        case (rc_state_reg)
            soc_pkg::RC_IDLE: begin
                rc_busy = 1'b0;
            end
            soc_pkg::RC_ISSUE: begin
                rc_issue = 1'b1;
            end
            soc_pkg::RC_DRAIN: begin
                rc_done = !p1_valid_reg && !p2_valid_reg;
            end
            default: begin
                rc_busy = 1'b0;
            end
        endcase
    end

    // Walk the window from the newest byte, checking each against its position.
    always_comb begin
        rp_next     = rp_reg;
        bp_next     = bp_reg;
        rc_pos_next = rc_pos_reg;
        acc_next    = acc_reg;
        if (s1_fire && rc_need) begin
            rp_next     = (wp_reg == '0) ? PLAST_I : wp_reg - IW'(1);
            bp_next     = len_eff[IW-1:0];
            rc_pos_next = len_eff[IW-1:0];
            acc_next    = 1'b1;
        end else if (rc_issue) begin
            rp_next = (rp_reg == '0) ? PLAST_I : rp_reg - IW'(1);
            bp_next = bp_reg - IW'(1);
        end
        if (p2_valid_reg) begin
            acc_next = acc_reg & mask_vld & mask_rd_data[p2_bp_reg];
        end
    end

    // Hold the result until the transfer completes.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            len_reg       <= '0;
            load_open_reg <= 1'b0;
            ovf_reg       <= 1'b0;
            seen_reg      <= '0;
            count_reg     <= '0;
            dv_reg        <= '0;
            wp_reg        <= '0;
            fwd_valid_reg <= 1'b0;
            rc_state_reg  <= soc_pkg::RC_IDLE;
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            len_reg       <= len_next;
            load_open_reg <= load_open_next;
            ovf_reg       <= ovf_next;
            seen_reg      <= seen_next;
            count_reg     <= count_next;
            dv_reg        <= dv_next;
            wp_reg        <= wp_next;
            if (!s1_stall) begin
                fwd_valid_reg <= mask_ctl.wr_en;
            end
            rc_state_reg  <= rc_state_next;
            p1_valid_reg  <= rc_issue;
            p2_valid_reg  <= p1_valid_reg;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_item_reg <= s_data;
        end
        if (!s1_stall) begin
            fwd_addr_reg <= mask_ctl.wr_addr;
            fwd_data_reg <= mask_wr_data;
        end
        rp_reg      <= rp_next;
        bp_reg      <= bp_next;
        rc_pos_reg  <= rc_pos_next;
        acc_reg     <= acc_next;
        p1_bp_reg   <= bp_reg;
        p2_bp_reg   <= p1_bp_reg;
        p2_byte_reg <= win_rd_data;
        if (out_load) begin
            m_data_reg.match_count      <= count_inc;
            m_data_reg.found            <= (count_inc != '0);
            m_data_reg.pattern_overflow <= ovf_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef NO_ASSERTIONS
    a_len_range: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= PMAX_L)
        else $error("pattern length beyond store");

    a_no_write_in_rebuild: assert property (@(posedge aclk) disable iff (!aresetn)
        rc_busy |-> !mask_ctl.wr_en)
        else $error("table written during rebuild");

    a_result_follows_last: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_valid_reg)
        else $error("last text byte gave no result");

    a_rebuild_pipe: assert property (@(posedge aclk) disable iff (!aresetn)
        p2_valid_reg |-> $past(p1_valid_reg))
        else $error("rebuild pipeline out of order");
`endif

endmodule

FILE: hw/rtl/soc_mask_table.sv
// Symbol-indexed table of pattern positions, with per-entry valid bits.
module soc_mask_table #(
    parameter int PATTERN_MAX = 64
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  soc_pkg::soc_mask_ctl_t ctl,
    input  logic [PATTERN_MAX-1:0] wr_data,
    output logic [PATTERN_MAX-1:0] rd_data,
    output logic                   vld
);

    logic [PATTERN_MAX-1:0]      mem [soc_pkg::SYMBOLS];
    logic [PATTERN_MAX-1:0]      rd_data_reg;
    logic [soc_pkg::SYMBOLS-1:0] vld_reg;
    logic [soc_pkg::SYMBOLS-1:0] vld_next;

    // Write the entry and register the read data.
    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            mem[ctl.wr_addr] <= wr_data;
        end
        if (ctl.rd_en) begin
            rd_data_reg <= mem[ctl.rd_addr];
        end
    end

    // Drop all entries at the start of a pattern, mark written ones.
    always_comb begin
        vld_next = ctl.clr ? '0 : vld_reg;
        if (ctl.wr_en) begin
            vld_next[ctl.wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign rd_data = rd_data_reg;
    assign vld     = vld_reg[ctl.vld_addr];

endmodule

FILE: hw/rtl/soc_text_window.sv
// Circular buffer of the most recent text bytes.
module soc_text_window #(
    parameter int PATTERN_MAX = 64,
    parameter int IW          = 6
) (
    input  logic                       aclk,
    input  logic                       wr_en,
    input  logic [IW-1:0]              wr_addr,
    input  logic [soc_pkg::BYTE_W-1:0] wr_data,
    input  logic                       rd_en,
    input  logic [IW-1:0]              rd_addr,
    output logic [soc_pkg::BYTE_W-1:0] rd_data
);

    logic [soc_pkg::BYTE_W-1:0] mem [PATTERN_MAX];
    logic [soc_pkg::BYTE_W-1:0] rd_data_reg;

    // Write the newest byte, register the read data.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
